// ===== rtl/core/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants for the box versus plane-set cull core.
// ----------------------------------------------------------------------------
package afc_pkg;

    // operation codes carried on tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // fixed field widths
    localparam int unsigned COORD_W  = 32;
    localparam int unsigned EXTENT_W = 31;
    localparam int unsigned INDEX_W  = 3;

    // datapath widths: c +/- e, one product, pair sums, full sum
    localparam int unsigned BOX_W  = COORD_W + 1;
    localparam int unsigned PROD_W = COORD_W + BOX_W;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam int unsigned TOT_W  = SUM_W + 1;

    // register stages between the plane read and the outside flag
    localparam int unsigned PIPE_DEPTH = 3;
    localparam int unsigned DRAIN_W    = 2;

    // one stored plane
    typedef struct packed {
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        logic [COORD_W-1:0] nz;
        logic [COORD_W-1:0] w;
    } plane_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // write one plane into the store
        logic start;   // capture box, clear outside flag
        logic issue;   // read one plane and push it down the pipe
        logic finish;  // load the result register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_stall;  // result register full and not taken
    } status_t;

endpackage

// ===== rtl/core/afc_ctrl.sv =====
// ----------------------------------------------------------------------------
// afc_ctrl
// Sequencer: accepts items, steps through the planes, drains the pipe.
// ----------------------------------------------------------------------------
module afc_ctrl #(
    parameter int unsigned PLANE_COUNT = 8,
    parameter int unsigned IDX_W       = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_op,
    output logic               s_tready,
    input  afc_pkg::status_t   status,
    output afc_pkg::cmd_t      cmd,
    output logic [IDX_W-1:0]   rd_addr
);

    afc_pkg::state_t                state_reg, state_next;
    logic [IDX_W-1:0]               cnt_reg, cnt_next;
    logic [afc_pkg::DRAIN_W-1:0]    dcnt_reg, dcnt_next;

    // state and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= afc_pkg::ST_IDLE;
            cnt_reg   <= '0;
            dcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dcnt_next  = dcnt_reg;
        case (state_reg)
            afc_pkg::ST_IDLE: begin
                if (s_tvalid && s_op == afc_pkg::OP_TEST) begin
                    state_next = afc_pkg::ST_RUN;
                    cnt_next   = '0;
                end
            end
            afc_pkg::ST_RUN: begin
                if (cnt_reg == IDX_W'(PLANE_COUNT - 1)) begin
                    state_next = afc_pkg::ST_DRAIN;
                    dcnt_next  = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            afc_pkg::ST_DRAIN: begin
                if (dcnt_reg == afc_pkg::DRAIN_W'(afc_pkg::PIPE_DEPTH - 1)) begin
                    state_next = afc_pkg::ST_FINISH;
                end else begin
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end
            afc_pkg::ST_FINISH: begin
                if (!status.out_stall) begin
                    state_next = afc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = afc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            afc_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.load  = s_tvalid && (s_op == afc_pkg::OP_LOAD);
                cmd.start = s_tvalid && (s_op == afc_pkg::OP_TEST);
            end
            afc_pkg::ST_RUN: begin
                cmd.issue = 1'b1;
            end
            afc_pkg::ST_DRAIN: begin
                cmd.issue = 1'b0;
            end
            afc_pkg::ST_FINISH: begin
                cmd.finish = !status.out_stall;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign rd_addr = cnt_reg;

endmodule

// ===== rtl/core/afc_datapath.sv =====
// ----------------------------------------------------------------------------
// afc_datapath
// Plane store, per-plane multiply pipeline, outside flag and result register.
// ----------------------------------------------------------------------------
module afc_datapath #(
    parameter int unsigned PLANE_COUNT = 8,
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned IDX_W       = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  afc_pkg::cmd_t                   cmd,
    input  logic [IDX_W-1:0]                rd_addr,
    output afc_pkg::status_t                status,
    input  logic [afc_pkg::INDEX_W-1:0]     plane_index,
    input  afc_pkg::plane_t                 plane_in,
    input  logic [afc_pkg::COORD_W-1:0]     center_x,
    input  logic [afc_pkg::COORD_W-1:0]     center_y,
    input  logic [afc_pkg::COORD_W-1:0]     center_z,
    input  logic [afc_pkg::EXTENT_W-1:0]    extent_x,
    input  logic [afc_pkg::EXTENT_W-1:0]    extent_y,
    input  logic [afc_pkg::EXTENT_W-1:0]    extent_z,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic                            intersects
);

    localparam int unsigned BOX_W  = afc_pkg::BOX_W;
    localparam int unsigned PROD_W = afc_pkg::PROD_W;
    localparam int unsigned SUM_W  = afc_pkg::SUM_W;
    localparam int unsigned TOT_W  = afc_pkg::TOT_W;

    // plane store
    afc_pkg::plane_t mem [0:PLANE_COUNT-1];
    afc_pkg::plane_t plane_q;

    logic [4:0]       idx_ext;
    logic             wr_ok;
    logic [IDX_W-1:0] wr_addr;

    assign idx_ext = {2'b00, plane_index};
    assign wr_ok   = idx_ext < 5'(PLANE_COUNT);
    assign wr_addr = idx_ext[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load && wr_ok) begin
            mem[wr_addr] <= plane_in;
        end
        if (cmd.issue) begin
            plane_q <= mem[rd_addr];
        end
    end

    // box terms c + e and c - e per axis
    logic signed [BOX_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [BOX_W-1:0] dif_x_reg, dif_y_reg, dif_z_reg;

    function automatic logic signed [BOX_W-1:0] box_add(
        input logic [afc_pkg::COORD_W-1:0]  c,
        input logic [afc_pkg::EXTENT_W-1:0] e,
        input logic                         sub
    );
        logic signed [BOX_W-1:0] cs;
        logic signed [BOX_W-1:0] es;
        cs = BOX_W'($signed(c));
        es = $signed({2'b00, e});
        return sub ? (cs - es) : (cs + es);
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            sum_x_reg <= box_add(center_x, extent_x, 1'b0);
            sum_y_reg <= box_add(center_y, extent_y, 1'b0);
            sum_z_reg <= box_add(center_z, extent_z, 1'b0);
            dif_x_reg <= box_add(center_x, extent_x, 1'b1);
            dif_y_reg <= box_add(center_y, extent_y, 1'b1);
            dif_z_reg <= box_add(center_z, extent_z, 1'b1);
        end
    end

    // pipeline valid tags
    logic rd_vld_reg, mul_vld_reg, add_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            add_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg  <= cmd.issue;
            mul_vld_reg <= rd_vld_reg;
            add_vld_reg <= mul_vld_reg;
        end
    end

    // per axis n*c - e*|n| folds into n*(c - e) or n*(c + e) by sign of n
    logic signed [BOX_W-1:0]  d_x, d_y, d_z;
    logic signed [PROD_W-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic [afc_pkg::COORD_W-1:0] w_reg;

    assign d_x = plane_q.nx[afc_pkg::COORD_W-1] ? sum_x_reg : dif_x_reg;
    assign d_y = plane_q.ny[afc_pkg::COORD_W-1] ? sum_y_reg : dif_y_reg;
    assign d_z = plane_q.nz[afc_pkg::COORD_W-1] ? sum_z_reg : dif_z_reg;

    assign prod_x_next = $signed(plane_q.nx) * d_x;
    assign prod_y_next = $signed(plane_q.ny) * d_y;
    assign prod_z_next = $signed(plane_q.nz) * d_z;

    always_ff @(posedge aclk) begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        prod_z_reg <= prod_z_next;
        w_reg      <= plane_q.w;
    end

    // pair sums, offset scaled to the product fraction
    logic signed [SUM_W-1:0] w_sh;
    logic signed [SUM_W-1:0] sum_a_next, sum_b_next;
    logic signed [SUM_W-1:0] sum_a_reg, sum_b_reg;

    assign w_sh       = SUM_W'($signed(w_reg)) <<< FRAC_BITS;
    assign sum_a_next = SUM_W'(prod_x_reg) + SUM_W'(prod_y_reg);
    assign sum_b_next = SUM_W'(prod_z_reg) - w_sh;

    always_ff @(posedge aclk) begin
        sum_a_reg <= sum_a_next;
        sum_b_reg <= sum_b_next;
    end

    // final sum and outside flag
    logic signed [TOT_W-1:0] total;
    logic                    positive;
    logic                    outside_reg;

    assign total    = TOT_W'(sum_a_reg) + TOT_W'(sum_b_reg);
    assign positive = !total[TOT_W-1] && (total != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outside_reg <= 1'b0;
        end else if (cmd.start) begin
            outside_reg <= 1'b0;
        end else if (add_vld_reg && positive) begin
            outside_reg <= 1'b1;
        end
    end

    // result register
    logic m_tvalid_reg;
    logic intersects_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            intersects_reg <= !outside_reg;
        end
    end

    assign status.out_stall = m_tvalid_reg && !m_tready;
    assign m_tvalid         = m_tvalid_reg;
    assign intersects       = intersects_reg;

endmodule

// ===== rtl/core/aabb_frustum_plane_cull_core.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_plane_cull_core
// Axis-aligned box test against a stored set of planes, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Input stream (s_): s_tuser selects the operation. A load transfer writes one
// plane (normal and offset) into slot plane_index and gives no result; slots
// at or beyond PLANE_COUNT are ignored. A test transfer gives a box center and
// half extent and returns one m_ transfer with intersects in m_tdata[0]:
// 0 when the box lies fully outside some plane, 1 otherwise. Every slot must
// be loaded before the first test.
// A test is accepted, then the planes go one per cycle through three shared
// multipliers, the pair-sum register and the outside flag, and the input is
// not ready again until the result register has been loaded. The plane
// store read port, one plane per cycle, sets the pace of a test.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a following test completes its planes and
// then holds until the earlier result is taken.
// Reset clears the control and the output valid; the plane store keeps no
// reset value and must be reloaded.
// ----------------------------------------------------------------------------
module aabb_frustum_plane_cull_core #(
    parameter int unsigned PLANE_COUNT = 8,
    parameter int unsigned FRAC_BITS   = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // plane_index, normal_x, normal_y, normal_z, plane_offset, center_x,
    // center_y, center_z, extent_x, extent_y, extent_z
    input  logic [319:0] s_tdata,
    // operation
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // intersects, zero filled
    output logic [7:0]   m_tdata
);

    localparam int unsigned IDX_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

    afc_pkg::cmd_t    cmd;
    afc_pkg::status_t status;
    logic [IDX_W-1:0] rd_addr;
    afc_pkg::plane_t  plane_in;
    logic             intersects;

    // unpack input fields
    assign plane_in.nx = s_tdata[34:3];
    assign plane_in.ny = s_tdata[66:35];
    assign plane_in.nz = s_tdata[98:67];
    assign plane_in.w  = s_tdata[130:99];

    afc_ctrl #(
        .PLANE_COUNT (PLANE_COUNT),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser[0]),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    afc_datapath #(
        .PLANE_COUNT (PLANE_COUNT),
        .FRAC_BITS   (FRAC_BITS),
        .IDX_W       (IDX_W)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .status      (status),
        .plane_index (s_tdata[2:0]),
        .plane_in    (plane_in),
        .center_x    (s_tdata[162:131]),
        .center_y    (s_tdata[194:163]),
        .center_z    (s_tdata[226:195]),
        .extent_x    (s_tdata[257:227]),
        .extent_y    (s_tdata[288:258]),
        .extent_z    (s_tdata[319:289]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .intersects  (intersects)
    );

    assign m_tdata = {7'b0, intersects};

    // no plane is read while the input side is open
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> !s_tready)
        else $error("plane read while input ready");

    // a result is never loaded over one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !(m_tvalid && !m_tready))
        else $error("result overwritten while stalled");

    // an accepted test closes the input on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == afc_pkg::OP_TEST) |=> !s_tready)
        else $error("input still open after test transfer");

    // output valid only rises after a finished test
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.finish))
        else $error("result without a finished test");

endmodule

// ===== test/aabb_frustum_plane_cull_core_tb.sv =====
// ----------------------------------------------------------------------------
// aabb_frustum_plane_cull_core_tb
// Self-checking bench for the box versus plane-set cull core. Plane loads and
// box tests are streamed into the core. A short directed table of boundary
// boxes comes first and types in some results; an in-bench model of the plane
// store and the exact wide plane-distance sums predicts the rest. Random loads
// and tests follow, in phases with and without idle cycles on both sides.
// ----------------------------------------------------------------------------
module aabb_frustum_plane_cull_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLANES       = 8;
    localparam int FRAC         = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int USE_MODEL    = -1;

    localparam logic [31:0] ONE     = 32'h0001_0000;
    localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] TEN     = 32'h000A_0000;

    // one input item, all fields unpacked
    typedef struct {
        logic        op;
        logic [2:0]  idx;
        logic [31:0] nx, ny, nz, w;
        logic [31:0] cx, cy, cz;
        logic [30:0] ex, ey, ez;
    } cull_item_t;

    // directed row: item plus typed-in result, or USE_MODEL
    typedef struct {
        cull_item_t item;
        int         typed_result;
    } cull_row_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // plane_index, normal_x, normal_y, normal_z, plane_offset, center_x,
    // center_y, center_z, extent_x, extent_y, extent_z
    logic [319:0] s_tdata  = '0;
    // operation
    logic [0:0]   s_tuser  = afc_pkg::OP_LOAD;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // intersects, zero filled
    logic [7:0]   m_tdata;

    // shadow of the plane store
    logic [31:0]  plane_nx [PLANES];
    logic [31:0]  plane_ny [PLANES];
    logic [31:0]  plane_nz [PLANES];
    logic [31:0]  plane_w  [PLANES];

    bit           intersects_q [$];
    cull_row_t    directed_rows [$];
    int           fail_count     = 0;
    int           idle_cycles    = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    aabb_frustum_plane_cull_core #(
        .PLANE_COUNT (PLANES),
        .FRAC_BITS   (FRAC)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // exact distance minus push per plane; outside when any is positive
    function automatic bit box_intersects(cull_item_t it);
        logic signed [127:0] cx, cy, cz, ex, ey, ez;
        logic signed [127:0] nx, ny, nz, w, excess;
        bit outside;
        outside = 1'b0;
        cx = $signed(it.cx);
        cy = $signed(it.cy);
        cz = $signed(it.cz);
        ex = {97'd0, it.ex};
        ey = {97'd0, it.ey};
        ez = {97'd0, it.ez};
        for (int p = 0; p < PLANES; p++) begin
            nx = $signed(plane_nx[p]);
            ny = $signed(plane_ny[p]);
            nz = $signed(plane_nz[p]);
            w  = $signed(plane_w[p]);
            excess = cx * nx + cy * ny + cz * nz - (w <<< FRAC)
                   - ex * ((nx < 0) ? -nx : nx)
                   - ey * ((ny < 0) ? -ny : ny)
                   - ez * ((nz < 0) ? -nz : nz);
            if (excess > 0) outside = 1'b1;
        end
        return !outside;
    endfunction

    function automatic logic [319:0] pack_item(cull_item_t it);
        return {it.ez, it.ey, it.ex, it.cz, it.cy, it.cx,
                it.w, it.nz, it.ny, it.nx, it.idx};
    endfunction

    // signed value spread evenly over +/- span
    function automatic logic [31:0] spread_q(int span);
        int v;
        v = int'($urandom_range(2 * span)) - span;
        return v;
    endfunction

    function automatic cull_row_t load_row(logic [2:0] idx, logic [31:0] nx,
                                           logic [31:0] ny, logic [31:0] nz,
                                           logic [31:0] w);
        cull_row_t r;
        r.item = '{op: afc_pkg::OP_LOAD, idx: idx, nx: nx, ny: ny, nz: nz, w: w,
                   cx: '0, cy: '0, cz: '0, ex: '0, ey: '0, ez: '0};
        r.typed_result = USE_MODEL;
        return r;
    endfunction

    function automatic cull_row_t test_row(logic [31:0] cx, logic [31:0] cy,
                                           logic [31:0] cz, logic [30:0] ex,
                                           logic [30:0] ey, logic [30:0] ez,
                                           int result);
        cull_row_t r;
        r.item = '{op: afc_pkg::OP_TEST, idx: '0, nx: '0, ny: '0, nz: '0, w: '0,
                   cx: cx, cy: cy, cz: cz, ex: ex, ey: ey, ez: ez};
        r.typed_result = result;
        return r;
    endfunction

    // random item: mostly near-origin boxes against plausible planes, some noise
    function automatic cull_item_t random_item();
        cull_item_t it;
        int kind;
        logic [31:0] unit;
        it.idx = 3'($urandom);
        it.nx  = $urandom;
        it.ny  = $urandom;
        it.nz  = $urandom;
        it.w   = $urandom;
        it.cx  = $urandom;
        it.cy  = $urandom;
        it.cz  = $urandom;
        it.ex  = 31'($urandom);
        it.ey  = 31'($urandom);
        it.ez  = 31'($urandom);
        kind   = $urandom_range(99);
        if ($urandom_range(99) < 30) begin
            it.op = afc_pkg::OP_LOAD;
            unit  = $urandom_range(1) ? ONE : NEG_ONE;
            if (kind < 50) begin
                // axis-aligned face of a box-shaped volume
                it.nx = '0;
                it.ny = '0;
                it.nz = '0;
                case ($urandom_range(2))
                    0: it.nx = unit;
                    1: it.ny = unit;
                    default: it.nz = unit;
                endcase
                it.w = $urandom_range(64 << FRAC);
            end else if (kind < 75) begin
                it.nx = spread_q(2 << FRAC);
                it.ny = spread_q(2 << FRAC);
                it.nz = spread_q(2 << FRAC);
                it.w  = spread_q(64 << FRAC);
            end
        end else begin
            it.op = afc_pkg::OP_TEST;
            if (kind < 70) begin
                it.cx = spread_q(48 << FRAC);
                it.cy = spread_q(48 << FRAC);
                it.cz = spread_q(48 << FRAC);
            end
            kind = $urandom_range(99);
            if (kind < 60) begin
                it.ex = 31'($urandom_range(16 << FRAC));
                it.ey = 31'($urandom_range(16 << FRAC));
                it.ez = 31'($urandom_range(16 << FRAC));
            end else if (kind >= 85) begin
                it.ex = '0;
                it.ey = '0;
                it.ez = '0;
            end
        end
        return it;
    endfunction

    // drive one item and wait for its transfer, with random idle cycles first
    task automatic send_item(cull_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= pack_item(it);
        do @(posedge aclk); while (!s_tready);
    endtask

    // update the shadow store or queue the expected result
    task automatic note_transfer(cull_item_t it, int typed_result);
        if (it.op == afc_pkg::OP_LOAD) begin
            plane_nx[it.idx] = it.nx;
            plane_ny[it.idx] = it.ny;
            plane_nz[it.idx] = it.nz;
            plane_w[it.idx]  = it.w;
        end else if (typed_result == USE_MODEL) begin
            intersects_q.push_back(box_intersects(it));
        end else begin
            intersects_q.push_back(typed_result[0]);
        end
    endtask

    // stimulus
    initial begin
        cull_item_t it;

        // box of half size ten around the origin, two neutral planes
        directed_rows.push_back(load_row(3'd0, ONE, '0, '0, TEN));
        directed_rows.push_back(load_row(3'd1, NEG_ONE, '0, '0, TEN));
        directed_rows.push_back(load_row(3'd2, '0, ONE, '0, TEN));
        directed_rows.push_back(load_row(3'd3, '0, NEG_ONE, '0, TEN));
        directed_rows.push_back(load_row(3'd4, '0, '0, ONE, TEN));
        directed_rows.push_back(load_row(3'd5, '0, '0, NEG_ONE, TEN));
        directed_rows.push_back(load_row(3'd6, '0, '0, '0, '0));
        directed_rows.push_back(load_row(3'd7, '0, '0, '0, '0));
        // point at origin, touching a face, just past it, box touching
        directed_rows.push_back(test_row('0, '0, '0, '0, '0, '0, 1));
        directed_rows.push_back(test_row(TEN, '0, '0, '0, '0, '0, 1));
        directed_rows.push_back(test_row(32'h000A_0001, '0, '0, '0, '0, '0, 0));
        directed_rows.push_back(test_row(32'h0014_0000, '0, '0, 31'h000A_0000,
                                         '0, '0, 1));
        // extreme centers and extents
        directed_rows.push_back(test_row(32'h7FFF_FFFF, '0, '0, 31'h7FFF_FFFF,
                                         '0, '0, 1));
        directed_rows.push_back(test_row(32'h8000_0000, '0, '0, '0, '0, '0, 0));
        directed_rows.push_back(test_row('0, 32'h000B_0000, '0, '0, '0, '0, 0));
        directed_rows.push_back(test_row('0, '0, 32'hFFF5_0000, '0, '0, '0, 0));
        directed_rows.push_back(test_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                         1));
        // extreme normals and offsets
        directed_rows.push_back(load_row(3'd7, 32'h8000_0000, 32'h8000_0000,
                                         32'h8000_0000, 32'h7FFF_FFFF));
        directed_rows.push_back(load_row(3'd6, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         32'h7FFF_FFFF, 32'h8000_0000));
        directed_rows.push_back(test_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                         USE_MODEL));
        directed_rows.push_back(test_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                         '0, '0, '0, USE_MODEL));
        directed_rows.push_back(test_row('0, '0, '0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                                         31'h7FFF_FFFF, USE_MODEL));
        directed_rows.push_back(test_row(32'h7FFF_FFFF, 32'h8000_0000, '0,
                                         31'd1, 31'd1, 31'd1, USE_MODEL));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item);
            note_transfer(directed_rows[i].item, directed_rows[i].typed_result);
        end

        // random phases: none, sender idle, receiver stall, both light
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                it = random_item();
                send_item(it);
                note_transfer(it, USE_MODEL);
            end
        end
        s_tvalid <= 1'b0;

        // drain
        while (intersects_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("aabb_frustum_plane_cull_core_tb passed");
        end else begin
            $display("aabb_frustum_plane_cull_core_tb failed");
        end
        $finish;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (intersects_q.size() == 0) begin
                $display("%0t: unexpected result transfer, intersects %0b",
                         $time, m_tdata[0]);
                fail_count++;
            end else if (m_tdata[0] !== intersects_q[0]) begin
                $display("%0t: intersects mismatch, expected %0b actual %0b",
                         $time, intersects_q[0], m_tdata[0]);
                fail_count++;
                void'(intersects_q.pop_front());
            end else begin
                void'(intersects_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("aabb_frustum_plane_cull_core_tb failed");
            $finish;
        end
    end

endmodule
